// ===== design/assert_macros.svh =====
// Assertion macros shared by the run histogram RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define LRRH_ASSERT_ALWAYS(lbl, clk_s, rstn_s, expr, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define LRRH_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LRRH_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lrrh_pkg.sv =====
// Shared types, defaults and helpers for the level-return run histogram.
// Used by lrrh_ctrl, lrrh_dp and level_return_run_histogram; no dependencies.
`default_nettype none

package lrrh_pkg;

    // Default sizes of the tracker table, the histograms and the compared sample.
    localparam int DEF_MAX_TRACKERS = 64;
    localparam int DEF_HIST_BINS    = 1024;
    localparam int DEF_SAMPLE_BITS  = 32;

    // Input transaction.
    typedef struct packed {
        logic               mode;
        logic signed [31:0] sample;
        logic [9:0]         bin_index;
    } in_item_t;

    // Result transaction.
    typedef struct packed {
        logic [31:0] rising_bin_count;
        logic [31:0] falling_bin_count;
        logic [31:0] rising_total;
        logic [31:0] falling_total;
        logic [9:0]  longest_run;
        logic [6:0]  open_trackers;
        logic [6:0]  runs_closed;
        logic        overflow;
    } out_item_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_INSERT,
        ST_READ,
        ST_RESP
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic walk_rd;
        logic read_hist;
        logic insert;
        logic load_result;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic rd_last;
        logic out_free;
    } dp_stat_t;

    // Increment that stops at all ones.
    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

`default_nettype wire

// ===== design/lrrh_ctrl.sv =====
// Sequencing state machine for the run histogram: clear pass, tracker walk,
// insertion, histogram read and result hand-off. Depends on lrrh_pkg.
`default_nettype none
`include "assert_macros.svh"

module lrrh_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire logic              item_mode,
    output logic                   item_stall,
    input  wire lrrh_pkg::dp_stat_t stat,
    output lrrh_pkg::dp_cmd_t      cmd
);

    lrrh_pkg::ctrl_state_t state_reg;
    lrrh_pkg::ctrl_state_t state_next;

    // State register; reset starts the memory clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrrh_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lrrh_pkg::ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = lrrh_pkg::ST_IDLE;
                end
            end
            lrrh_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = item_mode ? lrrh_pkg::ST_READ : lrrh_pkg::ST_WALK;
                end
            end
            lrrh_pkg::ST_WALK:
            begin
                if (stat.rd_last)
                begin
                    state_next = lrrh_pkg::ST_DRAIN;
                end
            end
            lrrh_pkg::ST_DRAIN:  state_next = lrrh_pkg::ST_INSERT;
            lrrh_pkg::ST_INSERT: state_next = lrrh_pkg::ST_RESP;
            lrrh_pkg::ST_READ:   state_next = lrrh_pkg::ST_RESP;
            lrrh_pkg::ST_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = lrrh_pkg::ST_IDLE;
                end
            end
            default: state_next = lrrh_pkg::ST_CLEAR;
        endcase
    end

    // Command decode.
    always_comb
    begin
        cmd             = '0;
        item_stall      = 1'b1;
        case (state_reg)
            lrrh_pkg::ST_CLEAR:  cmd.clear_step = 1'b1;
            lrrh_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                cmd.accept = item_valid;
            end
            lrrh_pkg::ST_WALK:   cmd.walk_rd = 1'b1;
            lrrh_pkg::ST_DRAIN:  cmd = '0;
            lrrh_pkg::ST_INSERT: cmd.insert = 1'b1;
            lrrh_pkg::ST_READ:   cmd.read_hist = 1'b1;
            lrrh_pkg::ST_RESP:   cmd.load_result = stat.out_free;
            default:             cmd = '0;
        endcase
    end

    // An accepted transaction holds off the input until its result is out.
    `LRRH_ASSERT_NEXT(a_accept_blocks, clk, rst_n, cmd.accept, item_stall,
                      "input open right after accept")
    // The clearing pass never overlaps a transaction.
    `LRRH_ASSERT_IMPL(a_clear_alone, clk, rst_n, cmd.clear_step,
                      item_stall && !cmd.load_result, "clear overlaps work")
    // Only the idle state takes a new transaction.
    `LRRH_ASSERT_IMPL(a_busy_stalls, clk, rst_n, state_reg != lrrh_pkg::ST_IDLE, item_stall,
                      "input open outside idle")

endmodule

`default_nettype wire

// ===== design/lrrh_dp.sv =====
// Datapath of the run histogram: tracker table, both histogram memories,
// totals, the read-modify-write pipeline and the result register. Depends on lrrh_pkg.
`default_nettype none
`include "assert_macros.svh"

module lrrh_dp #(
    parameter int MAX_TRACKERS = lrrh_pkg::DEF_MAX_TRACKERS,
    parameter int HIST_BINS    = lrrh_pkg::DEF_HIST_BINS,
    parameter int SAMPLE_BITS  = lrrh_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lrrh_pkg::in_item_t item,
    input  wire lrrh_pkg::dp_cmd_t  cmd,
    output lrrh_pkg::dp_stat_t      stat,
    input  wire logic               result_stall,
    output logic                    result_valid,
    output lrrh_pkg::out_item_t     result
);

    localparam int TR_W  = $clog2(MAX_TRACKERS);
    localparam int HB_W  = $clog2(HIST_BINS);
    localparam int OC_W  = $clog2(MAX_TRACKERS + 1);
    localparam int CLR_N = (HIST_BINS > MAX_TRACKERS) ? HIST_BINS : MAX_TRACKERS;
    localparam int CL_W  = $clog2(CLR_N);
    localparam int ENT_W = SAMPLE_BITS + HB_W + 2;
    localparam logic [HB_W-1:0]        RUN_MAX  = HB_W'(HIST_BINS - 1);
    localparam logic [SAMPLE_BITS-1:0] KEY_SIGN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    // Captured transaction.
    logic                   mode_reg;
    logic [SAMPLE_BITS-1:0] key_reg;
    logic [9:0]             bin_reg;
    logic [SAMPLE_BITS-1:0] key_in;

    // Tracker table: valid, run sign, run magnitude and start level per entry.
    logic [ENT_W-1:0] trk_mem [0:MAX_TRACKERS-1];
    logic [ENT_W-1:0] trk_rdata_reg;
    logic             trk_we;
    logic [TR_W-1:0]  trk_waddr;
    logic [ENT_W-1:0] trk_wdata;

    // Walk and clear counters.
    logic [TR_W-1:0] rd_addr_reg;
    logic [TR_W-1:0] eval_idx_reg;
    logic            eval_valid_reg;
    logic [CL_W-1:0] clr_idx_reg;
    logic            clr_hist_ok;
    logic            clr_trk_ok;

    // Per-sample bookkeeping.
    logic            free_found_reg;
    logic [TR_W-1:0] free_slot_reg;
    logic [OC_W-1:0] open_cnt_reg;
    logic [OC_W-1:0] closed_cnt_reg;
    logic [31:0]     rising_count_reg;
    logic [31:0]     falling_count_reg;
    logic [HB_W-1:0] longest_reg;
    logic            overflow_reg;

    // Evaluation of the entry read in the previous cycle.
    logic                   ent_valid;
    logic                   ent_neg;
    logic [HB_W-1:0]        ent_mag;
    logic [SAMPLE_BITS-1:0] ent_lvl;
    logic                   key_gt;
    logic                   key_lt;
    logic                   mag_nz;
    logic                   active;
    logic                   close_rise;
    logic                   close_fall;
    logic                   close_zero;
    logic                   closing;
    logic                   valid_after;
    logic                   neg_new;
    logic [HB_W-1:0]        mag_new;
    logic                   rise_inc;
    logic                   fall_inc;
    logic [HB_W-1:0]        close_bin;

    // Histogram memories and their update stage.
    logic [31:0]     rise_mem [0:HIST_BINS-1];
    logic [31:0]     fall_mem [0:HIST_BINS-1];
    logic [31:0]     rise_rdata_reg;
    logic [31:0]     fall_rdata_reg;
    logic            h_re;
    logic [HB_W-1:0] h_raddr;
    logic [HB_W-1:0] h_waddr;
    logic            rise_we;
    logic            fall_we;
    logic [31:0]     rise_wdata;
    logic [31:0]     fall_wdata;
    logic            upd_rise_reg;
    logic            upd_fall_reg;
    logic [HB_W-1:0] upd_bin_reg;
    logic            fwd_rise_reg;
    logic            fwd_fall_reg;
    logic [31:0]     rise_last_reg;
    logic [31:0]     fall_last_reg;
    logic [31:0]     rise_new;
    logic [31:0]     fall_new;

    // Result register.
    lrrh_pkg::out_item_t result_reg;
    lrrh_pkg::out_item_t result_next;
    logic                result_valid_reg;
    logic                bin_in_range;
    logic [31:0]         longest_ext;

    // Offset-binary key so that unsigned compare follows signed order.
    assign key_in = SAMPLE_BITS'($unsigned(item.sample)) ^ KEY_SIGN;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg <= item.mode;
            key_reg  <= key_in;
            bin_reg  <= item.bin_index;
        end
    end

    // Status toward the controller.
    assign stat.clear_last = (clr_idx_reg == CL_W'(CLR_N - 1));
    assign stat.rd_last    = (rd_addr_reg == TR_W'(MAX_TRACKERS - 1));
    assign stat.out_free   = !result_valid_reg || !result_stall;

    assign clr_hist_ok = cmd.clear_step && (32'(clr_idx_reg) < 32'(HIST_BINS));
    assign clr_trk_ok  = cmd.clear_step && (32'(clr_idx_reg) < 32'(MAX_TRACKERS));

    // Entry decode and the level comparison.
    assign ent_valid = trk_rdata_reg[ENT_W-1];
    assign ent_neg   = trk_rdata_reg[ENT_W-2];
    assign ent_mag   = trk_rdata_reg[SAMPLE_BITS+HB_W-1:SAMPLE_BITS];
    assign ent_lvl   = trk_rdata_reg[SAMPLE_BITS-1:0];
    assign key_gt    = key_reg > ent_lvl;
    assign key_lt    = key_reg < ent_lvl;
    assign mag_nz    = (ent_mag != '0);
    assign active    = eval_valid_reg && ent_valid;

    // A run closes when the sample crosses to the other side; a zero run on an equal sample.
    assign close_fall  = active && key_gt && ent_neg && mag_nz;
    assign close_rise  = active && key_lt && !ent_neg && mag_nz;
    assign close_zero  = active && !key_gt && !key_lt && !mag_nz;
    assign closing     = close_fall || close_rise || close_zero;
    assign valid_after = ent_valid && !closing;
    assign neg_new     = key_gt ? 1'b0 : (key_lt ? 1'b1 : ent_neg);
    assign mag_new     = (ent_mag != RUN_MAX) ? ent_mag + HB_W'(1) : ent_mag;
    assign rise_inc    = close_rise || close_zero;
    assign fall_inc    = close_fall || close_zero;
    assign close_bin   = close_zero ? '0 : ent_mag;

    // Tracker table write source: clearing pass, walk update or insertion.
    always_comb
    begin
        trk_we    = 1'b0;
        trk_waddr = eval_idx_reg;
        trk_wdata = {valid_after, neg_new, mag_new, ent_lvl};
        if (clr_trk_ok)
        begin
            trk_we    = 1'b1;
            trk_waddr = clr_idx_reg[TR_W-1:0];
            trk_wdata = '0;
        end
        else if (active)
        begin
            trk_we = 1'b1;
        end
        else if (cmd.insert && free_found_reg)
        begin
            trk_we    = 1'b1;
            trk_waddr = free_slot_reg;
            trk_wdata = {1'b1, 1'b0, {HB_W{1'b0}}, key_reg};
        end
    end

    // Tracker table storage with a registered read port.
    always_ff @(posedge clk)
    begin
        if (trk_we)
        begin
            trk_mem[trk_waddr] <= trk_wdata;
        end
        if (cmd.walk_rd)
        begin
            trk_rdata_reg <= trk_mem[rd_addr_reg];
            eval_idx_reg  <= rd_addr_reg;
        end
    end

    // Histogram read address: the requested bin on a histogram read, else the bin of a closing run.
    assign h_re    = rise_inc || fall_inc || cmd.read_hist;
    assign h_raddr = cmd.read_hist ? HB_W'(bin_reg) : close_bin;

    // Update stage: increment the bin, forwarding when the same bin was written last cycle.
    assign rise_new   = lrrh_pkg::sat_inc32(fwd_rise_reg ? rise_last_reg : rise_rdata_reg);
    assign fall_new   = lrrh_pkg::sat_inc32(fwd_fall_reg ? fall_last_reg : fall_rdata_reg);
    assign h_waddr    = clr_hist_ok ? clr_idx_reg[HB_W-1:0] : upd_bin_reg;
    assign rise_we    = clr_hist_ok || upd_rise_reg;
    assign fall_we    = clr_hist_ok || upd_fall_reg;
    assign rise_wdata = clr_hist_ok ? 32'd0 : rise_new;
    assign fall_wdata = clr_hist_ok ? 32'd0 : fall_new;

    // Histogram storage.
    always_ff @(posedge clk)
    begin
        if (rise_we)
        begin
            rise_mem[h_waddr] <= rise_wdata;
        end
        if (fall_we)
        begin
            fall_mem[h_waddr] <= fall_wdata;
        end
        if (h_re)
        begin
            rise_rdata_reg <= rise_mem[h_raddr];
            fall_rdata_reg <= fall_mem[h_raddr];
        end
    end

    // Update stage payload.
    always_ff @(posedge clk)
    begin
        upd_bin_reg <= close_bin;
        if (upd_rise_reg)
        begin
            rise_last_reg <= rise_new;
        end
        if (upd_fall_reg)
        begin
            fall_last_reg <= fall_new;
        end
    end

    // Control registers of the walk, the update stage and the totals.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_addr_reg       <= '0;
            eval_valid_reg    <= 1'b0;
            clr_idx_reg       <= '0;
            free_found_reg    <= 1'b0;
            free_slot_reg     <= '0;
            open_cnt_reg      <= '0;
            closed_cnt_reg    <= '0;
            rising_count_reg  <= '0;
            falling_count_reg <= '0;
            longest_reg       <= '0;
            overflow_reg      <= 1'b0;
            upd_rise_reg      <= 1'b0;
            upd_fall_reg      <= 1'b0;
            fwd_rise_reg      <= 1'b0;
            fwd_fall_reg      <= 1'b0;
        end
        else
        begin
            eval_valid_reg <= cmd.walk_rd;
            upd_rise_reg   <= rise_inc;
            upd_fall_reg   <= fall_inc;
            fwd_rise_reg   <= rise_inc && upd_rise_reg && (upd_bin_reg == close_bin);
            fwd_fall_reg   <= fall_inc && upd_fall_reg && (upd_bin_reg == close_bin);

            if (cmd.clear_step)
            begin
                clr_idx_reg <= clr_idx_reg + CL_W'(1);
            end

            if (cmd.accept)
            begin
                rd_addr_reg    <= '0;
                free_found_reg <= 1'b0;
                closed_cnt_reg <= '0;
            end
            else if (cmd.walk_rd)
            begin
                rd_addr_reg <= rd_addr_reg + TR_W'(1);
            end

            // Lowest slot that is free once the walk has passed it.
            if (eval_valid_reg && !valid_after && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_slot_reg  <= eval_idx_reg;
            end

            if (closing)
            begin
                closed_cnt_reg <= closed_cnt_reg + OC_W'(1);
                open_cnt_reg   <= open_cnt_reg - OC_W'(1);
            end
            else if (cmd.insert)
            begin
                if (free_found_reg)
                begin
                    open_cnt_reg <= open_cnt_reg + OC_W'(1);
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
            end

            if (close_rise)
            begin
                rising_count_reg <= lrrh_pkg::sat_inc32(rising_count_reg);
            end
            if (close_fall)
            begin
                falling_count_reg <= lrrh_pkg::sat_inc32(falling_count_reg);
            end
            if ((close_rise || close_fall) && (ent_mag > longest_reg))
            begin
                longest_reg <= ent_mag;
            end
        end
    end

    // Result assembly.
    assign bin_in_range = (32'(bin_reg) < 32'(HIST_BINS));
    assign longest_ext  = 32'(longest_reg);

    always_comb
    begin
        result_next                   = '0;
        result_next.rising_bin_count  = (mode_reg && bin_in_range) ? rise_rdata_reg : 32'd0;
        result_next.falling_bin_count = (mode_reg && bin_in_range) ? fall_rdata_reg : 32'd0;
        result_next.rising_total      = rising_count_reg;
        result_next.falling_total     = falling_count_reg;
        result_next.longest_run       = (longest_ext > 32'd1023) ? 10'd1023 : longest_ext[9:0];
        result_next.open_trackers     = 7'(open_cnt_reg);
        result_next.runs_closed       = 7'(closed_cnt_reg);
        result_next.overflow          = overflow_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            result_reg <= result_next;
        end
    end

    // Output register valid: set on load, dropped once the transaction is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The open count never passes the table size.
    `LRRH_ASSERT_ALWAYS(a_open_bound, clk, rst_n, 32'(open_cnt_reg) <= 32'(MAX_TRACKERS),
                        "open count above table size")
    // A recorded longest run implies at least one counted run.
    `LRRH_ASSERT_IMPL(a_longest_total, clk, rst_n, longest_reg != '0,
                      (rising_count_reg != 32'd0) || (falling_count_reg != 32'd0),
                      "longest run without a total")
    // A bin read must not race a pending histogram update.
    `LRRH_ASSERT_IMPL(a_read_quiet, clk, rst_n, cmd.read_hist,
                      !(upd_rise_reg || upd_fall_reg), "bin read during update")

endmodule

`default_nettype wire

// ===== design/level_return_run_histogram.sv =====
// Level-return run histogram, top level. A sample walks the tracker table, one entry per
// cycle, then drains, inserts the sample into a free slot if one is found and loads the result
// once the output register is free; a bin read reads both histograms and loads the result.
// Reset: asynchronous, active low; a clearing pass over max(HIST_BINS, MAX_TRACKERS) addresses
// zeroes both histograms and the tracker valid bits while the input stays stalled.
`default_nettype none

module level_return_run_histogram #(
    parameter int MAX_TRACKERS = lrrh_pkg::DEF_MAX_TRACKERS,
    parameter int HIST_BINS    = lrrh_pkg::DEF_HIST_BINS,
    parameter int SAMPLE_BITS  = lrrh_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire lrrh_pkg::in_item_t  item,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output lrrh_pkg::out_item_t      result
);

    lrrh_pkg::dp_cmd_t  cmd;
    lrrh_pkg::dp_stat_t stat;

    // Sequencing.
    lrrh_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_mode  (item.mode),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Tables, histograms and result register.
    lrrh_dp #(
        .MAX_TRACKERS (MAX_TRACKERS),
        .HIST_BINS    (HIST_BINS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire
